// File: rtl/rtsm_pkg.sv
// ----------------------------------------------------------------------------
// rtsm_pkg
// Shared types and constants for the three-wire serial clock-chip master.
// ----------------------------------------------------------------------------
package rtsm_pkg;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_TX_HI   = 3'd2,
        PH_TX_LO   = 3'd3,
        PH_RELEASE = 3'd4,
        PH_RX_HI   = 3'd5,
        PH_RX_LO   = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    // Action codes carried by each request
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd100;
    localparam logic [3:0] LAST_BYTE_BIT     = 4'd7;
    localparam logic [3:0] LAST_FRAME_BIT    = 4'd15;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] command;
        logic [7:0] write_data;
        logic       io_in;
    } item_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       busy;
        logic       done;
        logic [7:0] read_value;
    } result_t;

endpackage

// File: rtl/rtsm_engine.sv
// ----------------------------------------------------------------------------
// rtsm_engine
// Transaction sequencer state and its one-tick update; the result reflects
// the state after the update.
// ----------------------------------------------------------------------------
module rtsm_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  rtsm_pkg::item_t    item,
    input  logic [7:0]         half_period,
    output rtsm_pkg::result_t  result
);

    rtsm_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] tx_shift_reg, tx_shift_next;
    logic [7:0] data_hold_reg, data_hold_next;
    logic [7:0] rx_shift_reg, rx_shift_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic       is_write_reg, is_write_next;
    logic [7:0] last_value_reg, last_value_next;

    logic [7:0] half;
    logic       half_done;
    logic [3:0] hi_nib;
    logic [7:0] bcd_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rtsm_pkg::PH_IDLE;
            bit_index_reg  <= '0;
            tx_shift_reg   <= '0;
            data_hold_reg  <= '0;
            rx_shift_reg   <= '0;
            tick_count_reg <= '0;
            is_write_reg   <= 1'b0;
            last_value_reg <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            tx_shift_reg   <= tx_shift_next;
            data_hold_reg  <= data_hold_next;
            rx_shift_reg   <= rx_shift_next;
            tick_count_reg <= tick_count_next;
            is_write_reg   <= is_write_next;
            last_value_reg <= last_value_next;
        end
    end

    // high nibble * 10 + low nibble
    assign hi_nib  = rx_shift_reg[7:4];
    assign bcd_val = ({1'b0, hi_nib, 3'b000} + {3'b000, hi_nib, 1'b0})
                   + {4'b0000, rx_shift_reg[3:0]};

    always_comb
    begin
        half            = (half_period == 8'd0) ? 8'd1 : half_period;
        half_done       = (tick_count_reg >= half);
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        tx_shift_next   = tx_shift_reg;
        data_hold_next  = data_hold_reg;
        rx_shift_next   = rx_shift_reg;
        tick_count_next = tick_count_reg;
        is_write_next   = is_write_reg;
        last_value_next = last_value_reg;

        unique case (phase_reg)
            rtsm_pkg::PH_IDLE, rtsm_pkg::PH_DONE:
            begin
                if (item.action == rtsm_pkg::ACT_READ || item.action == rtsm_pkg::ACT_WRITE)
                begin
                    is_write_next   = (item.action == rtsm_pkg::ACT_WRITE);
                    tx_shift_next   = item.command;
                    data_hold_next  = item.write_data;
                    rx_shift_next   = '0;
                    bit_index_next  = '0;
                    phase_next      = rtsm_pkg::PH_START;
                    tick_count_next = 8'd1;
                end
                else
                begin
                    phase_next      = rtsm_pkg::PH_IDLE;
                    tick_count_next = '0;
                end
            end
            rtsm_pkg::PH_START:
            begin
                phase_next      = rtsm_pkg::PH_TX_HI;
                tick_count_next = 8'd1;
            end
            rtsm_pkg::PH_TX_HI:
            begin
                if (half_done)
                begin
                    phase_next      = rtsm_pkg::PH_TX_LO;
                    tick_count_next = 8'd1;
                end
                else
                    tick_count_next = tick_count_reg + 8'd1;
            end
            rtsm_pkg::PH_TX_LO:
            begin
                if (!half_done)
                    tick_count_next = tick_count_reg + 8'd1;
                else if (bit_index_reg == rtsm_pkg::LAST_BYTE_BIT && !is_write_reg)
                begin
                    bit_index_next  = '0;
                    phase_next      = rtsm_pkg::PH_RELEASE;
                    tick_count_next = 8'd1;
                end
                else if (bit_index_reg >= rtsm_pkg::LAST_FRAME_BIT)
                begin
                    bit_index_next  = '0;
                    phase_next      = rtsm_pkg::PH_DONE;
                    tick_count_next = 8'd1;
                end
                else
                begin
                    if (bit_index_reg == rtsm_pkg::LAST_BYTE_BIT)
                        tx_shift_next = data_hold_reg;
                    else
                        tx_shift_next = {1'b0, tx_shift_reg[7:1]};
                    bit_index_next  = bit_index_reg + 4'd1;
                    phase_next      = rtsm_pkg::PH_TX_HI;
                    tick_count_next = 8'd1;
                end
            end
            rtsm_pkg::PH_RELEASE:
            begin
                rx_shift_next   = rx_shift_reg | ({7'd0, item.io_in} << bit_index_reg[2:0]);
                phase_next      = rtsm_pkg::PH_RX_HI;
                tick_count_next = 8'd1;
            end
            rtsm_pkg::PH_RX_HI:
            begin
                if (half_done)
                begin
                    phase_next      = rtsm_pkg::PH_RX_LO;
                    tick_count_next = 8'd1;
                end
                else
                    tick_count_next = tick_count_reg + 8'd1;
            end
            rtsm_pkg::PH_RX_LO:
            begin
                if (!half_done)
                    tick_count_next = tick_count_reg + 8'd1;
                else if (bit_index_reg >= rtsm_pkg::LAST_BYTE_BIT)
                begin
                    last_value_next = bcd_val;
                    bit_index_next  = '0;
                    phase_next      = rtsm_pkg::PH_DONE;
                    tick_count_next = 8'd1;
                end
                else
                begin
                    // sample lands at the incremented bit position
                    bit_index_next  = bit_index_reg + 4'd1;
                    rx_shift_next   = rx_shift_reg
                                    | ({7'd0, item.io_in} << bit_index_next[2:0]);
                    phase_next      = rtsm_pkg::PH_RX_HI;
                    tick_count_next = 8'd1;
                end
            end
        endcase

        result.chip_enable  = (phase_next != rtsm_pkg::PH_IDLE)
                            && (phase_next != rtsm_pkg::PH_DONE);
        result.serial_clock = (phase_next == rtsm_pkg::PH_TX_HI)
                            || (phase_next == rtsm_pkg::PH_RX_HI);
        result.io_drive     = (phase_next == rtsm_pkg::PH_START)
                            || (phase_next == rtsm_pkg::PH_TX_HI)
                            || (phase_next == rtsm_pkg::PH_TX_LO);
        result.io_out       = result.io_drive & tx_shift_next[0];
        result.busy         = result.chip_enable;
        result.done         = (phase_next == rtsm_pkg::PH_DONE);
        result.read_value   = last_value_next;
    end

endmodule

// File: rtl/three_wire_rtc_serial_master_core.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_core
// Tick-driven master for a three-wire serial clock chip.
// ----------------------------------------------------------------------------
// Each request is one system tick: action 0 or 3 just advances time, 1 starts
// a read, 2 starts a write (starts are ignored while busy). A transaction
// raises chip_enable, clocks the command byte out LSB first with one
// half period of clock high and one of clock low per bit, then either sends
// write_data the same way or releases the data pin and samples the eight bits of
// io_in, one before each rising edge. The byte read comes back as high nibble * 10 +
// low nibble on read_value; done_res pulses for one tick at the end. Every
// request yields exactly one result, showing pin levels after that tick.
// Rate: one request per clock cycle unless out_ready stalls the output; a
// request passes the input register, then the sequencer update into the result register.
// The half period in ticks is set by cfg_wr_en/cfg_wr_data (reset 100,
// zero acts as one); write it only while no transaction is running.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_core
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] command,
    input  logic [7:0] write_data,
    input  logic       io_in,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       chip_enable,
    output logic       serial_clock,
    output logic       io_out,
    output logic       io_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_value
);

    logic              in_vld_reg;
    rtsm_pkg::item_t   item_reg;
    logic              out_vld_reg;
    rtsm_pkg::result_t res_reg;
    rtsm_pkg::result_t res_next;
    logic [7:0]        half_reg;
    logic              advance;

    // request moves from input register into the result register
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= rtsm_pkg::HALF_PERIOD_RESET;
        else if (cfg_wr_en)
            half_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.action     <= action;
            item_reg.command    <= command;
            item_reg.write_data <= write_data;
            item_reg.io_in      <= io_in;
        end
        if (advance)
            res_reg <= res_next;
    end

    rtsm_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .half_period (half_reg),
        .result      (res_next)
    );

    assign out_valid    = out_vld_reg;
    assign chip_enable  = res_reg.chip_enable;
    assign serial_clock = res_reg.serial_clock;
    assign io_out       = res_reg.io_out;
    assign io_drive     = res_reg.io_drive;
    assign busy_res     = res_reg.busy;
    assign done_res     = res_reg.done;
    assign read_value   = res_reg.read_value;

`ifndef ASSERT_OFF
    // data driven only when the pin is owned
    a_io_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && io_out |-> io_drive)
        else $error("io_out high without io_drive");

    // serial clock only pulses inside an enabled frame
    a_sclk_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && serial_clock |-> chip_enable)
        else $error("serial_clock high with chip_enable low");

    // the done pulse comes with enable already dropped
    a_done_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && done_res |-> !chip_enable && !io_drive)
        else $error("done_res with pins still active");

    // a stalled result keeps the queued request in place
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready && in_vld_reg |=> in_vld_reg && $stable(item_reg))
        else $error("queued request lost under output stall");
`endif

endmodule
